// ===== design/u2a_pkg.sv =====
`timescale 1ns / 1ps

package u2a_pkg;

  // Table sizes and the replacement length limit.
  localparam int CODE_SPACE       = 65536;
  localparam int POOL_DEPTH       = 65536;
  localparam int MAX_TRANSLIT_LEN = 63;

  localparam int IDX_AW  = $clog2(CODE_SPACE);
  localparam int POOL_AW = $clog2(POOL_DEPTH);
  localparam int LEN_W   = $clog2(MAX_TRANSLIT_LEN + 1);
  localparam int CP_W    = 21;

  // Input commands.
  localparam logic [1:0] CMD_SRC  = 2'd0;
  localparam logic [1:0] CMD_EOS  = 2'd1;
  localparam logic [1:0] CMD_IDX  = 2'd2;
  localparam logic [1:0] CMD_POOL = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_MISS = 2'd1;
  localparam logic [1:0] KIND_EOS  = 2'd2;

  // A finished, nonzero code point from the decoder.
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] cp;
  } u2a_cp_t;

endpackage

// ===== design/utf8_transliterate_to_ascii.sv =====
`timescale 1ns / 1ps

// Channel  Ports                                               Direction
// input    in_valid in_stall in_cmd in_byte in_table_address   into the block
//          in_table_offset
// result   out_valid out_stall out_kind out_byte               out of the block
//          out_code_point out_last
//
// Table writes, source bytes that finish no code point, and code points that
// halt are taken while the sequencer stays idle. An end of string, or a
// missing-character report for a code point past the index or with an index
// entry of zero, goes out through the single-result state. A lookup reads the
// index entry, then the length byte, and ends there when the length is zero;
// else it reads the replacement bytes in turn through the single pool read port.
// Reset is synchronous and active low; the tables keep no reset value.
// A stall on the result side holds the sequencer, so the input stalls too.

module utf8_transliterate_to_ascii import u2a_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_cmd,
  input  logic [7:0]      in_byte,
  input  logic [15:0]     in_table_address,
  input  logic [15:0]     in_table_offset,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_last
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ONE  = 3'd1;  // single result waits for the output
  localparam logic [2:0] S_IDX  = 3'd2;  // index entry arrives
  localparam logic [2:0] S_LEN  = 3'd3;  // length byte arrives
  localparam logic [2:0] S_BYTE = 3'd4;  // replacement byte arrives

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [CP_W-1:0]  cp_r, cp_nxt;
  logic [15:0]      base_r, base_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             pzero_r, pzero_nxt;

  logic             ov_r, ov_nxt;
  logic [1:0]       okind_r, okind_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic [CP_W-1:0]  ocp_r, ocp_nxt;
  logic             olast_r, olast_nxt;

  logic             acc, slot;
  logic             idx_we, pool_we, idx_re, pool_re;
  logic [15:0]      idx_rdata;
  logic [7:0]       pool_rdata;
  logic [16:0]      paddr;
  logic [7:0]       len_raw;
  logic [LEN_W-1:0] len_clip;
  logic [LEN_W-1:0] cnt_inc;
  u2a_cp_t          dec;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign slot     = !ov_r || !out_stall;

  // Table writes go straight into the memories; out of range writes are dropped.
  assign idx_we  = acc && (in_cmd == CMD_IDX) &&
                   ({1'b0, in_table_address} < 17'(CODE_SPACE));
  assign pool_we = acc && (in_cmd == CMD_POOL) &&
                   ({1'b0, in_table_address} < 17'(POOL_DEPTH));

  u2a_utf8 u_utf8 (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (acc && (in_cmd == CMD_SRC)),
    .clear   (acc && (in_cmd == CMD_EOS)),
    .byte_in (in_byte),
    .done    (dec)
  );

  u2a_ram #(.WIDTH(16), .DEPTH(CODE_SPACE)) u_index (
    .clk   (clk),
    .we    (idx_we),
    .waddr (in_table_address[IDX_AW-1:0]),
    .wdata (in_table_offset),
    .re    (idx_re),
    .raddr (dec.cp[IDX_AW-1:0]),
    .rdata (idx_rdata)
  );

  u2a_ram #(.WIDTH(8), .DEPTH(POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (in_table_address[POOL_AW-1:0]),
    .wdata (in_byte),
    .re    (pool_re),
    .raddr (paddr[POOL_AW-1:0]),
    .rdata (pool_rdata)
  );

  // The length byte is clipped to the limit; reads past the pool give zero.
  assign len_raw  = pzero_r ? 8'd0 : pool_rdata;
  assign len_clip = (len_raw > 8'(MAX_TRANSLIT_LEN)) ? LEN_W'(MAX_TRANSLIT_LEN)
                                                     : len_raw[LEN_W-1:0];
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cp_nxt    = cp_r;
    base_nxt  = base_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    idx_re    = 1'b0;
    pool_re   = 1'b0;
    paddr     = {1'b0, base_r};
    ov_nxt    = ov_r && out_stall;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    ocp_nxt   = ocp_r;
    olast_nxt = olast_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_cmd)
            CMD_SRC: begin
              if (dec.valid) begin
                cp_nxt = dec.cp;
                if (dec.cp >= CP_W'(CODE_SPACE)) begin
                  kind_nxt  = KIND_MISS;
                  state_nxt = S_ONE;
                end else begin
                  idx_re    = 1'b1;
                  state_nxt = S_IDX;
                end
              end
            end
            CMD_EOS: begin
              kind_nxt  = KIND_EOS;
              cp_nxt    = '0;
              state_nxt = S_ONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_ONE: begin
        if (slot) begin
          ov_nxt    = 1'b1;
          okind_nxt = kind_r;
          obyte_nxt = 8'd0;
          ocp_nxt   = cp_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_IDX: begin
        if (idx_rdata == 16'd0) begin
          kind_nxt  = KIND_MISS;
          state_nxt = S_ONE;
        end else begin
          base_nxt  = idx_rdata;
          paddr     = {1'b0, idx_rdata};
          pool_re   = 1'b1;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (len_clip == '0) begin
          state_nxt = S_IDLE;
        end else begin
          len_nxt   = len_clip;
          cnt_nxt   = LEN_W'(1);
          paddr     = {1'b0, base_r} + 17'd1;
          pool_re   = 1'b1;
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        if (slot) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_BYTE;
          obyte_nxt = pzero_r ? 8'd0 : pool_rdata;
          ocp_nxt   = '0;
          olast_nxt = (cnt_r == len_r);
          if (cnt_r == len_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_inc;
            paddr   = {1'b0, base_r} + 17'(cnt_inc);
            pool_re = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    pzero_nxt = pool_re ? (paddr >= 17'(POOL_DEPTH)) : pzero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    cp_r    <= cp_nxt;
    base_r  <= base_nxt;
    len_r   <= len_nxt;
    cnt_r   <= cnt_nxt;
    pzero_r <= pzero_nxt;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    ocp_r   <= ocp_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_kind       = okind_r;
  assign out_byte       = obyte_r;
  assign out_code_point = ocp_r;
  assign out_last       = olast_r;

endmodule

// ===== design/u2a_ram.sv =====
`timescale 1ns / 1ps

module u2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/u2a_utf8.sv =====
`timescale 1ns / 1ps

module u2a_utf8 import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       clear,
  input  logic [7:0] byte_in,
  output u2a_cp_t    done
);

  logic [1:0]      pend_r, pend_nxt;
  logic [2:0]      skip_r, skip_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            halt_r, halt_nxt;
  logic [CP_W-1:0] shifted;

  assign shifted = {part_r[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    pend_nxt   = pend_r;
    skip_nxt   = skip_r;
    part_nxt   = part_r;
    halt_nxt   = halt_r;
    done.valid = 1'b0;
    done.cp    = shifted;
    if (clear) begin
      pend_nxt = '0;
      skip_nxt = '0;
      part_nxt = '0;
      halt_nxt = 1'b0;
    end else if (step && !halt_r) begin
      if (skip_r != 3'd0) begin
        skip_nxt = skip_r - 3'd1;
      end else if (pend_r != 2'd0) begin
        part_nxt = shifted;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          // A decoded zero halts just as a NUL byte does.
          if (shifted == '0) begin
            halt_nxt = 1'b1;
          end else begin
            done.valid = 1'b1;
          end
        end
      end else if (byte_in == 8'h00) begin
        halt_nxt = 1'b1;
      end else if (byte_in[7] == 1'b0) begin
        done.valid = 1'b1;
        done.cp    = CP_W'(byte_in);
      end else if (byte_in[7:5] == 3'b110) begin
        part_nxt = CP_W'(byte_in[4:0]);
        pend_nxt = 2'd1;
      end else if (byte_in[7:4] == 4'b1110) begin
        part_nxt = CP_W'(byte_in[3:0]);
        pend_nxt = 2'd2;
      end else if (byte_in[7:3] == 5'b11110) begin
        part_nxt = CP_W'(byte_in[2:0]);
        pend_nxt = 2'd3;
      end else if (byte_in[7:2] == 6'b111110) begin
        skip_nxt = 3'd4;
      end else if (byte_in[7:1] == 7'b1111110) begin
        skip_nxt = 3'd5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      skip_r <= '0;
      part_r <= '0;
      halt_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      skip_r <= skip_nxt;
      part_r <= part_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== tb/u2a_checker.sv =====
`timescale 1ns / 1ps

module u2a_checker import u2a_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [1:0]      in_cmd,
  input  logic [7:0]      in_byte,
  input  logic [15:0]     in_table_address,
  input  logic [15:0]     in_table_offset,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [1:0]      out_kind,
  input  logic [7:0]      out_byte,
  input  logic [CP_W-1:0] out_code_point,
  input  logic            out_last,
  output int              fail_count,
  output int              results_pending
);

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      ascii;
    logic [CP_W-1:0] cp;
    logic            last;
  } u2a_result_t;

  u2a_result_t results_due[$];

  // Decoder state and the two lookup tables.
  logic [1:0]      cont_left;
  logic [2:0]      skip_left;
  logic [CP_W-1:0] cp_acc;
  logic            halted;
  logic [15:0]     index_mem [CODE_SPACE];
  logic [7:0]      pool_mem [POOL_DEPTH];

  u2a_result_t     got;
  u2a_result_t     want;

  function automatic logic [7:0] pool_at(input int addr);
    if (addr >= POOL_DEPTH) return 8'd0;
    return pool_mem[POOL_AW'(addr)];
  endfunction

  task automatic add_due(input logic [1:0] kind, input logic [7:0] ascii,
                         input logic [CP_W-1:0] cp, input logic last);
    u2a_result_t r;
    r.kind  = kind;
    r.ascii = ascii;
    r.cp    = cp;
    r.last  = last;
    results_due.push_back(r);
  endtask

  task automatic look_up_code_point(input logic [CP_W-1:0] cp);
    int base;
    int len;
    int i;
    if (cp == '0) begin
      halted = 1'b1;
    end else if (cp >= CODE_SPACE || index_mem[cp[15:0]] == 16'd0) begin
      add_due(KIND_MISS, 8'd0, cp, 1'b1);
    end else begin
      base = int'(index_mem[cp[15:0]]);
      len  = int'(pool_at(base));
      if (len > MAX_TRANSLIT_LEN) len = MAX_TRANSLIT_LEN;
      for (i = 1; i <= len; i++) begin
        add_due(KIND_BYTE, pool_at(base + i), '0, i == len);
      end
    end
  endtask

  task automatic decode_source_byte(input logic [7:0] b);
    if (halted) return;
    if (skip_left != 3'd0) begin
      skip_left = skip_left - 3'd1;
      return;
    end
    if (cont_left != 2'd0) begin
      cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) look_up_code_point(cp_acc);
    end else if (b == 8'h00) begin
      halted = 1'b1;
    end else if (!b[7]) begin
      look_up_code_point(CP_W'(b));
    end else if (b[7:5] == 3'b110) begin
      cp_acc    = CP_W'(b[4:0]);
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc    = CP_W'(b[3:0]);
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc    = CP_W'(b[2:0]);
      cont_left = 2'd3;
    end else if (b[7:2] == 6'b111110) begin
      skip_left = 3'd4;
    end else if (b[7:1] == 7'b1111110) begin
      skip_left = 3'd5;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Inputs are predicted before outputs are matched, so a result that the
  // block could produce in the same cycle already has its expectation queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      cont_left       = '0;
      skip_left       = '0;
      cp_acc          = '0;
      halted          = 1'b0;
      fail_count      = 0;
      results_pending = 0;
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        case (in_cmd)
          CMD_SRC: decode_source_byte(in_byte);
          CMD_EOS: begin
            cont_left = '0;
            skip_left = '0;
            cp_acc    = '0;
            halted    = 1'b0;
            add_due(KIND_EOS, 8'd0, '0, 1'b1);
          end
          CMD_IDX: begin
            if (in_table_address < CODE_SPACE) index_mem[in_table_address] = in_table_offset;
          end
          default: begin
            if (in_table_address < POOL_DEPTH) pool_mem[in_table_address] = in_byte;
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        got.kind  = out_kind;
        got.ascii = out_byte;
        got.cp    = out_code_point;
        got.last  = out_last;
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d byte 0x%02h code point 0x%06h last %0d",
                 got.kind, got.ascii, got.cp, got.last);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("out_byte", 32'(want.ascii), 32'(got.ascii));
          check_field("code_point", 32'(want.cp), 32'(got.cp));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
      results_pending = results_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb import u2a_pkg::*; ();

  // The watchdog fires after this many cycles in which neither channel moves
  // an item. The longest legal quiet stretch is one long idle gap, so this
  // leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  // Items of every kind to send over the whole run, table loads included.
  localparam int ITEM_TOTAL     = 230;
  // Cycles to keep watching after the last expected result has arrived.
  localparam int SETTLE_CYCLES  = 20;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [1:0]      in_cmd;
  logic [7:0]      in_byte;
  logic [15:0]     in_table_address;
  logic [15:0]     in_table_offset;
  logic            out_valid;
  logic            out_stall;
  logic [1:0]      out_kind;
  logic [7:0]      out_byte;
  logic [CP_W-1:0] out_code_point;
  logic            out_last;

  int fail_count;
  int results_pending;

  // Bookkeeping for the stimulus only. The tables in the block have no reset
  // value, so the stimulus must never decode a code point whose index entry
  // was not loaded, nor point an entry at pool bytes that were not loaded.
  // These arrays record what has been loaded so far.
  bit idx_written [CODE_SPACE];
  int mapped_cps[$];
  int str_base[$];
  int str_len[$];
  int pool_next = 1;

  int idle_cycles  = 0;
  int items_sent   = 0;
  int send_calm    = 0;
  int stall_calm   = 0;

  utf8_transliterate_to_ascii u_dut (.*);

  u2a_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Most gaps are short, a few are long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // A continuation byte carrying six payload bits. The top two bits are not
  // checked by the decoder, so now and then they are something other than 10.
  function automatic logic [7:0] tail(input logic [5:0] bits);
    logic [1:0] hi;
    hi = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
    return {hi, bits};
  endfunction

  // The result side stalls in bursts of random length, with calm stretches
  // in which it takes every result as soon as it is offered.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_calm > 0) begin
        stall_calm--;
        n = 0;
      end else begin
        n = gap_cycles();
        if ($urandom_range(0, 29) == 0) stall_calm = $urandom_range(20, 60);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  end

  // Any accepted item on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item after an optional idle gap and returns at the falling
  // edge after it was taken. Called and returning at a falling edge, so the
  // valid line is never lowered and raised within one time step.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                           input logic [15:0] a, input logic [15:0] o);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = gap_cycles();
      if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_byte          <= b;
    in_table_address <= a;
    in_table_offset  <= o;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Fields that a command ignores carry random values so every bit toggles.
  task automatic src(input logic [7:0] b);
    send_item(CMD_SRC, b, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic end_of_string();
    send_item(CMD_EOS, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
  endtask

  task automatic write_pool(input int addr, input int value);
    send_item(CMD_POOL, 8'(value), 16'(addr), 16'($urandom_range(0, 65535)));
  endtask

  task automatic write_index(input int cp, input int offs);
    send_item(CMD_IDX, 8'($urandom_range(0, 255)), 16'(cp), 16'(offs));
    if (cp != 0 && !idx_written[IDX_AW'(cp)]) mapped_cps.push_back(cp);
    idx_written[IDX_AW'(cp)] = 1'b1;
  endtask

  // Holds the sender back until the block has delivered everything owed.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
  endtask

  // Loads a length byte and as many replacement bytes as will be read. A
  // length above the limit is stored as is, but only the truncated count of
  // bytes behind it is ever read.
  task automatic load_string(input int len_field, output int base);
    int n;
    int i;
    base = pool_next;
    n = (len_field > MAX_TRANSLIT_LEN) ? MAX_TRANSLIT_LEN : len_field;
    write_pool(base, len_field);
    for (i = 1; i <= n; i++) write_pool(base + i, $urandom_range(0, 255));
    pool_next = base + n + 1;
    str_base.push_back(base);
    str_len.push_back(n);
  endtask

  // Gives a code point an index entry before it can be decoded: either no
  // replacement, an existing string, or a freshly loaded one. Lengths are
  // mostly short, sometimes zero, and rarely beyond the truncation limit.
  task automatic map_code_point(input int cp);
    int r;
    int base;
    int len_field;
    if (cp == 0 || cp >= CODE_SPACE || idx_written[IDX_AW'(cp)]) return;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      base = 0;
    end else if (r < 50 && str_base.size() > 0) begin
      base = str_base[$urandom_range(0, str_base.size() - 1)];
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) len_field = $urandom_range(MAX_TRANSLIT_LEN + 1, 255);
      else if (r < 10) len_field = 0;
      else len_field = $urandom_range(1, 6);
      load_string(len_field, base);
    end
    write_index(cp, base);
  endtask

  // Sends a code point in the given UTF-8 form (1 to 4 bytes). A form longer
  // than needed gives an overlong encoding, which the decoder accepts. With
  // late_map set, the index entry is loaded between the lead byte and the
  // continuation bytes, which checks that table writes act mid-character.
  task automatic send_code_point(input int cp, input int form, input bit late_map);
    logic [20:0] v;
    v = CP_W'(cp);
    if (!late_map || form == 1) map_code_point(cp);
    case (form)
      1:       src({1'b0, v[6:0]});
      2:       src({3'b110, v[10:6]});
      3:       src({4'b1110, v[15:12]});
      default: src({5'b11110, v[20:18]});
    endcase
    if (late_map && form != 1) map_code_point(cp);
    if (form == 4) src(tail(v[17:12]));
    if (form >= 3) src(tail(v[11:6]));
    if (form >= 2) src(tail(v[5:0]));
  endtask

  // A well-formed character: often one already in the tables, otherwise
  // fresh random payload bits in a random form.
  task automatic send_random_char();
    int cp;
    int form;
    if (mapped_cps.size() > 0 && $urandom_range(0, 99) < 55) begin
      cp = mapped_cps[$urandom_range(0, mapped_cps.size() - 1)];
      form = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : 3;
      if ($urandom_range(0, 9) == 0) form = $urandom_range(form, 4);
    end else begin
      form = $urandom_range(1, 4);
      case (form)
        1: cp = $urandom_range(1, 'h7f);
        2: cp = $urandom_range(0, 'h7ff);
        3: cp = $urandom_range(0, 'hffff);
        default: begin
          cp = $urandom_range(0, 1) ? $urandom_range(0, 'hffff)
                                    : $urandom_range(0, 'h1fffff);
        end
      endcase
    end
    send_code_point(cp, form, $urandom_range(0, 3) == 0);
  endtask

  // Bytes that break the normal flow, or table traffic in mid-string.
  task automatic send_noise();
    int k;
    int cp;
    case ($urandom_range(0, 4))
      0: src(8'($urandom_range('h80, 'hbf)));
      1: src(8'($urandom_range('hfe, 'hff)));
      2: begin
        // A 5 or 6 byte form swallows the bytes behind it, whatever they are.
        k = $urandom_range(0, 1);
        src(k ? 8'($urandom_range('hfc, 'hfd)) : 8'($urandom_range('hf8, 'hfb)));
        repeat (k ? 5 : 4) src(8'($urandom_range(0, 255)));
      end
      3: begin
        // Halt on a NUL byte or an overlong zero; what follows is ignored.
        if ($urandom_range(0, 1)) src(8'h00);
        else send_code_point(0, $urandom_range(2, 4), 1'b0);
        repeat ($urandom_range(0, 4)) src(8'($urandom_range(0, 255)));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: write_pool($urandom_range(32768, 65535), $urandom_range(0, 255));
          1: begin
            k = $urandom_range(0, str_base.size() - 1);
            if (str_len[k] > 0) begin
              write_pool(str_base[k] + $urandom_range(1, str_len[k]), $urandom_range(0, 255));
            end
          end
          default: begin
            cp = mapped_cps[$urandom_range(0, mapped_cps.size() - 1)];
            k  = $urandom_range(0, str_base.size() - 1);
            write_index(cp, $urandom_range(0, 1) ? 0 : str_base[k]);
          end
        endcase
      end
    endcase
  endtask

  // A character cut short right before the end of the string.
  task automatic send_truncated();
    int form;
    int n;
    form = $urandom_range(2, 5);
    case (form)
      2:       src(8'($urandom_range('hc0, 'hdf)));
      3:       src(8'($urandom_range('he0, 'hef)));
      4:       src(8'($urandom_range('hf0, 'hf7)));
      default: src(8'($urandom_range('hf8, 'hfd)));
    endcase
    n = (form == 5) ? $urandom_range(0, 3) : $urandom_range(0, form - 2);
    repeat (n) src(tail(6'($urandom_range(0, 63))));
  endtask

  initial begin
    int base;
    int n;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_SRC;
    in_byte          = 8'd0;
    in_table_address = 16'd0;
    in_table_offset  = 16'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. First the tables: a two byte string holding the byte
    // extremes, a zero-length string, a string at the very top of the pool
    // whose bytes fall beyond its end, and one whose length gets truncated.
    write_pool(1, 2);
    write_pool(2, 8'h00);
    write_pool(3, 8'hff);
    write_pool(4, 0);
    str_base.push_back(1);
    str_len.push_back(2);
    str_base.push_back(4);
    str_len.push_back(0);
    pool_next = 5;
    write_pool(16'hffff, 3);
    write_index('h41, 1);
    write_index('h42, 4);
    write_index('h7f, 0);
    write_index('hffff, 16'hffff);
    write_index(0, 0);
    load_string(200, base);
    write_index('he9, base);

    src(8'h41);                        // plain replacement
    src(8'h42);                        // zero length: nothing comes out
    src(8'h7f);                        // entry of zero: missing report
    send_code_point('h41, 2, 1'b0);    // overlong form of a mapped character
    send_code_point('hffff, 3, 1'b0);  // pool read past the top reads zero
    send_code_point('he9, 2, 1'b0);    // replacement cut to the length limit
    send_code_point('h10000, 4, 1'b0); // first code point past the index
    send_code_point('h1fffff, 4, 1'b0);
    src(8'h80);                        // stray continuations and bad leads
    src(8'hbf);
    src(8'hfe);
    src(8'hff);
    src(8'hf8);
    repeat (4) src(8'($urandom_range(0, 255)));
    src(8'hfd);
    repeat (5) src(8'($urandom_range(0, 255)));
    send_code_point('hc0, 2, 1'b1);    // index written between lead and tail
    end_of_string();
    src(8'h00);                        // NUL halts until the end of string
    src(8'h41);
    end_of_string();
    src(8'hc0);                        // an overlong zero halts too
    src(8'h80);
    src(8'h41);
    end_of_string();
    src(8'he2);                        // partial character is dropped
    src(8'h82);
    end_of_string();
    src(8'hf8);                        // pending skip is dropped
    src(8'h41);
    end_of_string();
    src(8'h41);
    end_of_string();
    drain();

    // Random part: strings of mostly well-formed characters with some noise,
    // now and then cut short, each closed by an end of string.
    while (items_sent < ITEM_TOTAL) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        if ($urandom_range(0, 99) < 82) send_random_char();
        else send_noise();
      end
      if ($urandom_range(0, 9) == 0) send_truncated();
      end_of_string();
      if ($urandom_range(0, 14) == 0) drain();
    end

    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
